FILE: hdl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, codes and sizes for the buffer slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

	localparam int MaxSlots  = 16;
	localparam int SlotW     = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
	localparam int CountW    = 5;
	localparam int StrideW   = 32;
	localparam int FuncW     = 3;
	localparam int IndexW    = 8;
	localparam int StatusW   = 3;
	localparam int GrantW    = 4;
	localparam int SizeW     = 36;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 32;
	localparam int InDataW   = 16;
	localparam int OutDataW  = 80;

	typedef enum logic [1:0] {
		SLOT_IDLE   = 2'd0,
		SLOT_USE    = 2'd1,
		SLOT_FLIGHT = 2'd2
	} slot_st_t;

	typedef enum logic [FuncW-1:0] {
		FN_ACQUIRE = 3'd0,
		FN_SUBMIT  = 3'd1,
		FN_RELEASE = 3'd2,
		FN_REVERT  = 3'd3,
		FN_QUERY   = 3'd4
	} func_t;

	typedef enum logic [StatusW-1:0] {
		RC_OK    = 3'd0,
		RC_FULL  = 3'd1,
		RC_INDEX = 3'd2,
		RC_STATE = 3'd3,
		RC_NOCFG = 3'd4
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SLOT_COUNT  = 1'd0,
		REG_SLOT_STRIDE = 1'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EVAL = 2'd1,
		ST_MUL  = 2'd2
	} ctrl_st_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/bsp_ctrl.sv
// ----------------------------------------------------------------------------
// bsp_ctrl
// Request sequencer: capture, evaluate, compute offset and load the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  bsp_pkg::dp_stat_t stat,
	output bsp_pkg::ctrl_cmd_t cmd
);
	import bsp_pkg::*;

	ctrl_st_t state_q;
	ctrl_st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				if (!stat.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/bsp_dp.sv
// ----------------------------------------------------------------------------
// bsp_dp
// Slot state table, configuration registers, grant logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wr,
	input  wire [bsp_pkg::CfgIdxW-1:0]      cfg_idx,
	input  wire [bsp_pkg::CfgDataW-1:0]     cfg_wdata,
	input  wire [bsp_pkg::FuncW-1:0]        in_func,
	input  wire [bsp_pkg::IndexW-1:0]       in_slot_sel,
	input  bsp_pkg::ctrl_cmd_t              cmd,
	output bsp_pkg::dp_stat_t               stat,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [bsp_pkg::StatusW-1:0]     out_status,
	output logic [bsp_pkg::GrantW-1:0]      out_granted_slot,
	output logic [bsp_pkg::SizeW-1:0]       out_slot_offset,
	output logic [bsp_pkg::SizeW-1:0]       out_pool_bytes
);
	import bsp_pkg::*;

	logic [CountW-1:0]   count_q;
	logic [StrideW-1:0]  stride_q;
	slot_st_t            slot_st_q [MaxSlots];
	slot_st_t            slot_st_d [MaxSlots];

	logic [FuncW-1:0]    func_q;
	logic [IndexW-1:0]   idx_q;

	status_t             status_s1;
	logic [SlotW-1:0]    slot_s1;
	logic                ok_s1;
	logic [SizeW-1:0]    size_s1;

	logic                out_valid_q;
	status_t             status_q;
	logic [GrantW-1:0]   grant_q;
	logic [SizeW-1:0]    offset_q;
	logic [SizeW-1:0]    size_q;

	logic                cfg_ok;
	logic [MaxSlots-1:0] free;
	logic                hit;
	logic [SlotW-1:0]    pick;
	logic                idx_in;
	logic [SlotW-1:0]    idx_sl;
	slot_st_t            cur;
	status_t             status_d;
	logic [SlotW-1:0]    slot_d;
	logic                ok_d;
	logic [CountW+StrideW-1:0] size_prod;
	logic [SizeW-1:0]    off_prod;

	assign cfg_ok = (count_q != '0) && (stride_q != '0) && (int'(count_q) <= MaxSlots);
	assign idx_in = idx_q < IndexW'(count_q);
	assign idx_sl = idx_q[SlotW-1:0];
	assign cur    = slot_st_q[idx_sl];
	assign size_prod = CountW'(count_q) * StrideW'(stride_q);
	assign off_prod  = SizeW'(stride_q) * SizeW'(slot_s1);

	always_comb begin
		hit  = 1'b0;
		pick = '0;
		for (int i = 0; i < MaxSlots; i++) begin
			free[i] = (slot_st_q[i] == SLOT_IDLE) && (i < int'(count_q));
		end
		for (int i = MaxSlots - 1; i >= 0; i--) begin
			if (free[i]) begin
				hit  = 1'b1;
				pick = SlotW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MaxSlots; i++) begin
			slot_st_d[i] = slot_st_q[i];
		end
		status_d = RC_OK;
		slot_d   = '0;
		ok_d     = 1'b0;
		if (!cfg_ok) begin
			status_d = RC_NOCFG;
		end else if (func_q == FN_ACQUIRE) begin
			if (hit) begin
				slot_st_d[pick] = SLOT_USE;
				slot_d          = pick;
				ok_d            = 1'b1;
			end else begin
				status_d = RC_FULL;
			end
		end else if (func_q > FN_QUERY) begin
			status_d = RC_STATE;
		end else if (!idx_in) begin
			status_d = RC_INDEX;
		end else begin
			slot_d = idx_sl;
			case (func_q)
				FN_SUBMIT: begin
					if (cur == SLOT_USE) slot_st_d[idx_sl] = SLOT_FLIGHT;
					else status_d = RC_STATE;
				end
				FN_RELEASE: begin
					if (cur == SLOT_FLIGHT) slot_st_d[idx_sl] = SLOT_IDLE;
					else status_d = RC_STATE;
				end
				FN_REVERT: begin
					if (cur == SLOT_USE) slot_st_d[idx_sl] = SLOT_IDLE;
					else status_d = RC_STATE;
				end
				default: begin
				end
			endcase
			ok_d = (status_d == RC_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			stride_q <= '0;
			for (int i = 0; i < MaxSlots; i++) begin
				slot_st_q[i] <= SLOT_IDLE;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SLOT_COUNT:  count_q  <= cfg_wdata[CountW-1:0];
				REG_SLOT_STRIDE: stride_q <= cfg_wdata[StrideW-1:0];
				default: begin
				end
			endcase
			for (int i = 0; i < MaxSlots; i++) begin
				slot_st_q[i] <= SLOT_IDLE;
			end
		end else if (cmd.eval) begin
			for (int i = 0; i < MaxSlots; i++) begin
				slot_st_q[i] <= slot_st_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			idx_q  <= in_slot_sel;
		end
		if (cmd.eval) begin
			status_s1 <= status_d;
			slot_s1   <= slot_d;
			ok_s1     <= ok_d;
			size_s1   <= cfg_ok ? SizeW'(size_prod) : '0;
		end
		if (cmd.load_out) begin
			status_q <= status_s1;
			grant_q  <= GrantW'(slot_s1);
			offset_q <= ok_s1 ? off_prod : '0;
			size_q   <= size_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_full    = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign out_status       = status_q;
	assign out_granted_slot = grant_q;
	assign out_slot_offset  = offset_q;
	assign out_pool_bytes   = size_q;

endmodule

`default_nettype wire

FILE: hdl/buffer_slot_pool.sv
// ----------------------------------------------------------------------------
// buffer_slot_pool
// Allocator for a pool of equal-sized buffer slots (idle, in use, in flight).
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one beat per request; each request
// yields exactly one result beat on m_axis, in request order.
// Configuration (slot count, slot stride) is written over the cfg channel,
// which is always ready; a write returns every slot to idle. Write it only
// while no request is outstanding.
// After the request beat is accepted, m_axis_tvalid rises once the request
// has passed evaluation (with the size multiply) and the offset multiply
// into the output register. One request is in work at a time, so the block
// takes no new request until capture, evaluate and output load are through.
// The next request is accepted while a finished result still waits in the
// output register; if the receiver stalls, the following result holds in
// its stage until the output register frees, and s_axis_tready stays low.
// Reset clears the configuration registers to zero (pool not configured),
// all slots to idle and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_slot_pool (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [bsp_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire [bsp_pkg::CfgDataW-1:0]     cfg_data,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// [2:0] func, [10:3] slot_sel, [15:11] zero
	input  wire [bsp_pkg::InDataW-1:0]      s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// [2:0] status, [6:3] granted_slot, [42:7] slot_offset,
	// [78:43] pool_bytes, [79] zero
	output logic [bsp_pkg::OutDataW-1:0]    m_axis_tdata
);
	import bsp_pkg::*;

	ctrl_cmd_t           cmd;
	dp_stat_t            stat;
	logic [StatusW-1:0]  status;
	logic [GrantW-1:0]   granted_slot;
	logic [SizeW-1:0]    slot_offset;
	logic [SizeW-1:0]    pool_bytes;

	assign cfg_ready = 1'b1;

	bsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr           (cfg_valid && cfg_ready),
		.cfg_idx          (cfg_index),
		.cfg_wdata        (cfg_data),
		.in_func          (s_axis_tdata[FuncW-1:0]),
		.in_slot_sel      (s_axis_tdata[FuncW+IndexW-1:FuncW]),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_status       (status),
		.out_granted_slot (granted_slot),
		.out_slot_offset  (slot_offset),
		.out_pool_bytes   (pool_bytes)
	);

	assign m_axis_tdata = {1'b0, pool_bytes, slot_offset, granted_slot, status};

	a_capture_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.eval)
		else $error("capture not followed by evaluation");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |=> !s_axis_tready)
		else $error("request accepted while offset stage busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("result overwritten while stalled");

	a_nocfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status == RC_NOCFG) |->
			(slot_offset == '0 && pool_bytes == '0 && granted_slot == '0))
		else $error("unconfigured result carries data");

endmodule

`default_nettype wire

FILE: tb/sv/tb_buffer_slot_pool.sv
// ----------------------------------------------------------------------------
// tb_buffer_slot_pool
// Self-checking bench for the buffer slot pool allocator.
// ----------------------------------------------------------------------------
// A directed table covers the unconfigured pool, the widest pool, every
// function, bad indexes, wrong states, unknown functions and a full pool.
// Random phases follow, each under its own register setting. Most requests
// in these phases follow the slot life cycle, and the rest are noise. Both
// sides idle at random. One phase holds the result side off long enough to
// back the block up. Check rows are held to the table; every other result
// beat is checked against an in-bench model of slot states and registers.
// ----------------------------------------------------------------------------

module tb_buffer_slot_pool;
	timeunit 1ns;
	timeprecision 1ps;

	import bsp_pkg::*;

	localparam int Period     = 10;
	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 80;
	localparam int SettleCyc  = 4;
	localparam int NDir       = 32;
	localparam int NPhase     = 10;
	localparam int MaxReport  = 10;

	localparam logic [FuncW-1:0] FN_RSVD5 = 3'd5;
	localparam logic [FuncW-1:0] FN_RSVD7 = 3'd7;
	localparam logic [SizeW-1:0] SizeMax  = '1;
	localparam logic [SizeW-1:0] SzFull   = 36'hFFFFFFFF0;
	localparam logic [SizeW-1:0] SzOne    = 36'h0FFFFFFFF;

	typedef struct packed {
		status_t            status;
		logic [GrantW-1:0]  slot;
		logic [SizeW-1:0]   offset;
		logic [SizeW-1:0]   size;
	} pool_result_t;

	localparam pool_result_t NoRes = '{RC_OK, 4'd0, 36'd0, 36'd0};

	typedef enum logic [1:0] {
		ROW_CFG = 2'd0,
		ROW_REQ = 2'd1,
		ROW_CHK = 2'd2
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		reg_idx_t            regsel;
		logic [CfgDataW-1:0] val;
		logic [FuncW-1:0]    fn;
		logic [IndexW-1:0]   idx;
		pool_result_t        res;
	} row_t;

	row_t dir_rows [NDir] = '{
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, '{RC_NOCFG, 4'd0, 36'd0, 36'd0}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd255, '{RC_NOCFG, 4'd0, 36'd0, 36'd0}},
		'{ROW_CFG, REG_SLOT_COUNT, 32'd16, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, '{RC_NOCFG, 4'd0, 36'd0, 36'd0}},
		'{ROW_CFG, REG_SLOT_STRIDE, 32'hFFFFFFFF, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, '{RC_OK, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd15,
			'{RC_OK, 4'd15, 36'hEFFFFFFF1, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd16, '{RC_INDEX, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_SUBMIT, 8'd255, '{RC_INDEX, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_SUBMIT, 8'd0, '{RC_OK, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_SUBMIT, 8'd0, '{RC_STATE, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_REVERT, 8'd0, '{RC_STATE, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_RELEASE, 8'd0, '{RC_OK, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_RELEASE, 8'd0, '{RC_STATE, 4'd0, 36'd0, SzFull}},
		'{ROW_REQ, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_REQ, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd170, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_REVERT, 8'd1, '{RC_OK, 4'd1, SzOne, SzFull}},
		'{ROW_REQ, REG_SLOT_COUNT, 32'd0, FN_SUBMIT, 8'd15, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_RSVD5, 8'd0, '{RC_STATE, 4'd0, 36'd0, SzFull}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_RSVD7, 8'd255, '{RC_STATE, 4'd0, 36'd0, SzFull}},
		'{ROW_CFG, REG_SLOT_COUNT, 32'd1, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, '{RC_OK, 4'd0, 36'd0, SzOne}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd85, '{RC_FULL, 4'd0, 36'd0, SzOne}},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd1, '{RC_INDEX, 4'd0, 36'd0, SzOne}},
		'{ROW_CFG, REG_SLOT_COUNT, 32'd17, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, '{RC_NOCFG, 4'd0, 36'd0, 36'd0}},
		'{ROW_CFG, REG_SLOT_COUNT, 32'hFFFFFFFF, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CHK, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd0, '{RC_NOCFG, 4'd0, 36'd0, 36'd0}},
		'{ROW_CFG, REG_SLOT_COUNT, 32'd16, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_CFG, REG_SLOT_STRIDE, 32'd1, FN_ACQUIRE, 8'd0, NoRes},
		'{ROW_REQ, REG_SLOT_COUNT, 32'd0, FN_QUERY, 8'd9, NoRes},
		'{ROW_REQ, REG_SLOT_COUNT, 32'd0, FN_ACQUIRE, 8'd0, NoRes}
	};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index     = '0;
	logic [CfgDataW-1:0]  cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InDataW-1:0]   s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutDataW-1:0]  m_axis_tdata;

	slot_st_t            slot_st [MaxSlots];
	logic [CountW-1:0]   cfg_count  = '0;
	logic [StrideW-1:0]  cfg_stride = '0;

	pool_result_t pending_q [$];
	pool_result_t got_res;
	pool_result_t want_res;

	bit burst     = 1'b0;
	bit hold_arm  = 1'b0;
	bit hold_done = 1'b0;

	int mismatches = 0;
	int n_req      = 0;
	int n_res      = 0;
	int n_settings = 0;
	int cycles     = 0;
	int status_seen [5] = '{0, 0, 0, 0, 0};

	buffer_slot_pool dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(Period / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic pool_result_t pool_apply(input logic [FuncW-1:0] fn,
			input logic [IndexW-1:0] idx);
		pool_result_t r;
		logic [63:0]  total;
		slot_st_t     cur;
		int           i;
		bit           hit;
		r = NoRes;
		hit = 1'b0;
		total = 64'(cfg_count) * 64'(cfg_stride);
		if (cfg_count == '0 || cfg_stride == '0 || int'(cfg_count) > MaxSlots ||
				total > 64'(SizeMax)) begin
			r.status = RC_NOCFG;
			return r;
		end
		r.size = total[SizeW-1:0];
		if (fn == FN_ACQUIRE) begin
			r.status = RC_FULL;
			for (i = 0; i < int'(cfg_count); i++) begin
				if (!hit && slot_st[i] == SLOT_IDLE) begin
					hit = 1'b1;
					slot_st[i] = SLOT_USE;
					r.status = RC_OK;
					r.slot = GrantW'(i);
					r.offset = SizeW'(64'(i) * 64'(cfg_stride));
				end
			end
		end else if (fn > FN_QUERY) begin
			r.status = RC_STATE;
		end else if (32'(idx) >= 32'(cfg_count)) begin
			r.status = RC_INDEX;
		end else begin
			cur = slot_st[idx[SlotW-1:0]];
			r.slot = idx[GrantW-1:0];
			case (fn)
				FN_SUBMIT: begin
					if (cur == SLOT_USE) slot_st[idx[SlotW-1:0]] = SLOT_FLIGHT;
					else r.status = RC_STATE;
				end
				FN_RELEASE: begin
					if (cur == SLOT_FLIGHT) slot_st[idx[SlotW-1:0]] = SLOT_IDLE;
					else r.status = RC_STATE;
				end
				FN_REVERT: begin
					if (cur == SLOT_USE) slot_st[idx[SlotW-1:0]] = SLOT_IDLE;
					else r.status = RC_STATE;
				end
				default: begin
				end
			endcase
			if (r.status == RC_OK) r.offset = SizeW'(64'(idx) * 64'(cfg_stride));
		end
		return r;
	endfunction

	function automatic void pool_write(input reg_idx_t regsel, input logic [CfgDataW-1:0] d);
		if (regsel == REG_SLOT_COUNT) cfg_count = d[CountW-1:0];
		else cfg_stride = d;
		foreach (slot_st[i]) slot_st[i] = SLOT_IDLE;
	endfunction

	task automatic write_reg(input reg_idx_t regsel, input logic [CfgDataW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= regsel;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pool_write(regsel, d);
		n_settings++;
	endtask

	task automatic send_req(input logic [FuncW-1:0] fn, input logic [IndexW-1:0] idx,
			input bit typed, input pool_result_t res);
		int gap;
		pool_result_t predicted;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (cfg_valid) cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(InDataW - FuncW - IndexW){1'b0}}, idx, fn};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = pool_apply(fn, idx);
		pending_q.push_back(typed ? res : predicted);
		n_req++;
	endtask

	// hold off until every result is back and the pipe has settled
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	task automatic pick_req(output logic [FuncW-1:0] fn, output logic [IndexW-1:0] idx);
		int       roll;
		int       lim;
		int       i;
		int       cands [$];
		slot_st_t need;
		roll = $urandom_range(0, 99);
		lim = (cfg_count == '0) ? 0 : int'(cfg_count) - 1;
		idx = IndexW'($urandom_range(0, 255));
		if (roll < 12) begin
			fn = FuncW'($urandom_range(0, 7));
		end else if (roll < 42) begin
			fn = FN_ACQUIRE;
		end else if (roll < 52) begin
			fn = FN_QUERY;
			idx = IndexW'($urandom_range(0, lim + 1));
		end else begin
			case ($urandom_range(0, 4))
				0, 1: begin
					fn = FN_SUBMIT;
					need = SLOT_USE;
				end
				2, 3: begin
					fn = FN_RELEASE;
					need = SLOT_FLIGHT;
				end
				default: begin
					fn = FN_REVERT;
					need = SLOT_USE;
				end
			endcase
			for (i = 0; i < MaxSlots && i < int'(cfg_count); i++)
				if (slot_st[i] == need) cands.push_back(i);
			if (cands.size() != 0 && $urandom_range(0, 4) != 0)
				idx = IndexW'(cands[$urandom_range(0, cands.size() - 1)]);
			else
				idx = IndexW'($urandom_range(0, lim));
		end
	endtask

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 9);
			if (hold_arm && !hold_done) begin
				stall = HoldCycles;
				hold_done = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res.status = status_t'(m_axis_tdata[2:0]);
			got_res.slot   = m_axis_tdata[6:3];
			got_res.offset = m_axis_tdata[42:7];
			got_res.size   = m_axis_tdata[78:43];
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReport)
					$display("unexpected result beat: status %0d slot %0d offset %h size %h",
						got_res.status, got_res.slot, got_res.offset, got_res.size);
			end else begin
				want_res = pending_q.pop_front();
				if (int'(want_res.status) < 5) status_seen[want_res.status]++;
				n_res++;
				if (got_res !== want_res || m_axis_tdata[OutDataW-1] !== 1'b0) begin
					mismatches++;
					if (mismatches <= MaxReport)
						$display({"result %0d mismatch: expected status %0d slot %0d ",
							"offset %h size %h, got status %0d slot %0d offset %h size %h ",
							"pad %b"}, n_res, want_res.status, want_res.slot,
							want_res.offset, want_res.size, got_res.status, got_res.slot,
							got_res.offset, got_res.size, m_axis_tdata[OutDataW-1]);
				end
			end
		end
	end

	initial begin
		logic [FuncW-1:0]    fn;
		logic [IndexW-1:0]   idx;
		logic [CfgDataW-1:0] cnt_d;
		logic [CfgDataW-1:0] stride_d;
		int                  n_items;
		int                  p;
		foreach (slot_st[i]) slot_st[i] = SLOT_IDLE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_CFG: begin
					drain();
					write_reg(dir_rows[r].regsel, dir_rows[r].val);
				end
				ROW_REQ: send_req(dir_rows[r].fn, dir_rows[r].idx, 1'b0, NoRes);
				default: send_req(dir_rows[r].fn, dir_rows[r].idx, 1'b1, dir_rows[r].res);
			endcase
		end

		for (p = 0; p < NPhase; p++) begin
			stride_d = $urandom();
			n_items = 120;
			case (p)
				0: begin
					cnt_d = 32'd16;
					stride_d = 32'hFFFFFFFF;
				end
				1: begin
					cnt_d = 32'd1;
					stride_d = 32'd1;
					n_items = 60;
				end
				2: begin
					cnt_d = 32'd16;
					stride_d = 32'd0;
					n_items = 12;
				end
				3: begin
					cnt_d = 32'd0;
					n_items = 12;
				end
				4: begin
					cnt_d = 32'($urandom_range(MaxSlots + 1, 31));
					n_items = 12;
				end
				5: begin
					cnt_d = 32'd4;
					stride_d = 32'd4096;
				end
				6: cnt_d = 32'($urandom_range(1, MaxSlots));
				7: cnt_d = 32'd16;
				8: begin
					cnt_d = 32'($urandom_range(1, MaxSlots));
					stride_d = 32'($urandom_range(1, 255));
					n_items = 100;
				end
				default: begin
					cnt_d = 32'd2;
					stride_d = 32'h80000000;
					n_items = 60;
				end
			endcase
			cnt_d = ($urandom() & ~32'h1F) | cnt_d;
			drain();
			burst = (p == 5 || p == 7);
			hold_arm = (p == 5);
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_SLOT_COUNT, cnt_d);
				write_reg(REG_SLOT_STRIDE, stride_d);
			end else begin
				write_reg(REG_SLOT_STRIDE, stride_d);
				write_reg(REG_SLOT_COUNT, cnt_d);
			end
			repeat (n_items) begin
				pick_req(fn, idx);
				send_req(fn, idx, 1'b0, NoRes);
			end
		end

		drain();
		burst = 1'b0;
		repeat (2 * SettleCyc) @(posedge clk);

		$display("Sent %0d requests across %0d register writes; %0d results checked.",
			n_req, n_settings, n_res);
		$display("Status mix: ok %0d, full %0d, bad index %0d, wrong state %0d, unconfigured %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/bsp_pkg.sv
hdl/bsp_ctrl.sv
hdl/bsp_dp.sv
hdl/buffer_slot_pool.sv
tb/sv/tb_buffer_slot_pool.sv
